// File: hdl/cmpc_pkg.sv
package cmpc_pkg;

  // signed q32.16 working format
  typedef logic signed [47:0] q48_t;

  localparam int DUTY_MIN_DEF = 10;
  localparam int DUTY_MAX_DEF = 390;
  localparam int POS_DIV_DEF  = 100;
  localparam int VEL_DIV_DEF  = 10;

  // configuration register indexes
  localparam logic [1:0] REG_TARGET    = 2'd0;
  localparam logic [1:0] REG_VEL_LIMIT = 2'd1;
  localparam logic [1:0] REG_CUR_LIMIT = 2'd2;

  // shift codes of the shared multiplier
  typedef logic [2:0] sh_t;
  localparam sh_t SH_0  = 3'd0;
  localparam sh_t SH_16 = 3'd1;
  localparam sh_t SH_24 = 3'd2;
  localparam sh_t SH_32 = 3'd3;
  localparam sh_t SH_33 = 3'd4;

  // constant factors
  localparam logic [24:0] POS_RCP   = 25'd20822589;  // counts to rad, q24
  localparam logic [24:0] VEL_K     = 25'd13107200;  // 200 in q16
  localparam logic [24:0] G_PP      = 25'd98304;
  localparam logic [24:0] G_PD      = 25'd13107;
  localparam logic [24:0] G_VI      = 25'd1147;
  localparam logic [24:0] G_VAW     = 25'd43516;
  localparam logic [24:0] G_CP      = 25'd85197;
  localparam logic [24:0] G_CI      = 25'd1311;
  localparam logic [24:0] G_KT      = 25'd4476;
  localparam logic [24:0] G_CAW     = 25'd79233;
  localparam logic [24:0] K_MILLI   = 25'd1000;
  localparam logic [24:0] WRAP_RCP  = 25'd1367823;   // floor(2^33 / 6280)
  localparam logic [24:0] MILLI_RCP = 25'd4294967;   // floor(2^32 / 1000)

  localparam logic signed [33:0] WRAP_OFFSET = 34'sd2147483680;  // 341956 turns
  localparam logic [13:0] WRAP_MRAD = 14'd6280;

  localparam logic signed [63:0] Q48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] Q48_MIN = -Q48_MAX - 64'sd1;
  localparam logic signed [63:0] I32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] I32_MIN = -I32_MAX - 64'sd1;

  typedef struct packed {
    logic              start;
    logic signed [49:0] a;
    logic [24:0]       k;
    sh_t               sh;
    logic              rnd;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic signed [58:0] r;
  } mul_rsp_t;

  function automatic q48_t sat48(input logic signed [63:0] x);
    q48_t y;
    if (x > Q48_MAX) y = Q48_MAX[47:0];
    else if (x < Q48_MIN) y = Q48_MIN[47:0];
    else y = x[47:0];
    return y;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] y;
    if (x > I32_MAX) y = I32_MAX[31:0];
    else if (x < I32_MIN) y = I32_MIN[31:0];
    else y = x[31:0];
    return y;
  endfunction

  function automatic mul_req_t mk_req(input logic signed [49:0] a, input logic [24:0] k,
                                      input sh_t sh, input logic rnd);
    mul_req_t m;
    m.start = 1'b1;
    m.a     = a;
    m.k     = k;
    m.sh    = sh;
    m.rnd   = rnd;
    return m;
  endfunction

endpackage

// File: hdl/cmpc_if.sv
interface cmpc_tick_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] encoder_count;
  logic [9:0]        current_sample;
  modport source(output valid, encoder_count, current_sample, input ready);
  modport sink(input valid, encoder_count, current_sample, output ready);
endinterface

interface cmpc_result_if;
  logic              valid;
  logic              ready;
  logic [8:0]        pwm_high_compare;
  logic [8:0]        pwm_low_compare;
  logic signed [5:0] drive_volts;
  logic signed [31:0] velocity_mrad_s;
  logic signed [15:0] current_ma;
  modport source(output valid, pwm_high_compare, pwm_low_compare, drive_volts,
                 velocity_mrad_s, current_ma, input ready);
  modport sink(input valid, pwm_high_compare, pwm_low_compare, drive_volts,
               velocity_mrad_s, current_ma, output ready);
endinterface

interface cmpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/cmpc_mul.sv
module cmpc_mul (
  input  logic               clk,
  input  logic               rst,
  input  cmpc_pkg::mul_req_t req,
  output cmpc_pkg::mul_rsp_t rsp
);
  import cmpc_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LO   = 3'd1;
  localparam logic [2:0] PH_HI   = 3'd2;
  localparam logic [2:0] PH_SUM  = 3'd3;
  localparam logic [2:0] PH_OUT  = 3'd4;

  logic [2:0]  phase;
  logic [49:0] mag;
  logic        neg;
  logic [24:0] k;
  sh_t         sh;
  logic        rnd;
  logic [49:0] plo;
  logic [49:0] phi;
  logic [24:0] mop;
  logic [49:0] pp;
  logic [74:0] sum;
  logic [74:0] rc;
  logic [74:0] shifted;

  // one 25 x 25 multiplier, low half of the operand first, then the high half
  assign mop = (phase == PH_LO) ? mag[24:0] : mag[49:25];
  assign pp  = mop * k;

  always_comb begin
    case (sh)
      SH_16:   rc = 75'(1) << 15;
      SH_24:   rc = 75'(1) << 23;
      SH_32:   rc = 75'(1) << 31;
      SH_33:   rc = 75'(1) << 32;
      default: rc = '0;
    endcase
    if (!rnd) rc = '0;
  end

  always_comb begin
    case (sh)
      SH_16:   shifted = sum >> 16;
      SH_24:   shifted = sum >> 24;
      SH_32:   shifted = sum >> 32;
      SH_33:   shifted = sum >> 33;
      default: shifted = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (req.start) begin
            neg   <= req.a[49];
            mag   <= req.a[49] ? 50'(-req.a) : 50'(req.a);
            k     <= req.k;
            sh    <= req.sh;
            rnd   <= req.rnd;
            phase <= PH_LO;
          end
        end
        PH_LO: begin
          plo   <= pp;
          phase <= PH_HI;
        end
        PH_HI: begin
          phi   <= pp;
          phase <= PH_SUM;
        end
        PH_SUM: begin
          sum   <= {phi, 25'b0} + 75'(plo) + rc;
          phase <= PH_OUT;
        end
        PH_OUT: begin
          rsp.r    <= neg ? -$signed({1'b0, shifted[57:0]}) : $signed({1'b0, shifted[57:0]});
          rsp.done <= 1'b1;
          phase    <= PH_IDLE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/cascaded_motor_position_controller.sv
// channel   role   beat contents
// tick      sink   encoder_count, current_sample (one 0.5 ms control tick)
// result    source pwm_high_compare, pwm_low_compare, drive_volts, velocity_mrad_s,
//                  current_ma (one beat per tick)
// cfg       sink   index, data (register write, always ready)
//
// one multiplier shared by every product that the sequencer issues
// tick ready only while idle; the result register holds a beat while the sink stalls
// synchronous reset clears loop state, tick phase and result valid
module cascaded_motor_position_controller #(
  parameter int DUTY_MIN         = cmpc_pkg::DUTY_MIN_DEF,
  parameter int DUTY_MAX         = cmpc_pkg::DUTY_MAX_DEF,
  parameter int POSITION_DIVIDER = cmpc_pkg::POS_DIV_DEF,
  parameter int VELOCITY_DIVIDER = cmpc_pkg::VEL_DIV_DEF
) (
  input logic           clk,
  input logic           rst,
  cmpc_tick_if.sink     tick,
  cmpc_result_if.source result,
  cmpc_cfg_if.sink      cfg
);
  import cmpc_pkg::*;

  localparam int TW = $clog2(POSITION_DIVIDER);
  localparam int VW = (VELOCITY_DIVIDER > 1) ? $clog2(VELOCITY_DIVIDER) : 1;

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_WAIT    = 5'd1;
  localparam logic [4:0] S_POS     = 5'd2;
  localparam logic [4:0] S_WRAP_Q  = 5'd3;
  localparam logic [4:0] S_WRAP_C  = 5'd4;
  localparam logic [4:0] S_CONV_Q  = 5'd5;
  localparam logic [4:0] S_CONV_C  = 5'd6;
  localparam logic [4:0] S_ERR     = 5'd7;
  localparam logic [4:0] S_PD0     = 5'd8;
  localparam logic [4:0] S_PD1     = 5'd9;
  localparam logic [4:0] S_PD2     = 5'd10;
  localparam logic [4:0] S_PCLAMP  = 5'd11;
  localparam logic [4:0] S_VEL0    = 5'd12;
  localparam logic [4:0] S_VEL1    = 5'd13;
  localparam logic [4:0] S_VEL2    = 5'd14;
  localparam logic [4:0] S_VEL3    = 5'd15;
  localparam logic [4:0] S_VEL4    = 5'd16;
  localparam logic [4:0] S_VEL5    = 5'd17;
  localparam logic [4:0] S_VCLAMP  = 5'd18;
  localparam logic [4:0] S_VAW     = 5'd19;
  localparam logic [4:0] S_CUR0    = 5'd20;
  localparam logic [4:0] S_CUR1    = 5'd21;
  localparam logic [4:0] S_CUR2    = 5'd22;
  localparam logic [4:0] S_CUR3    = 5'd23;
  localparam logic [4:0] S_CUR4    = 5'd24;
  localparam logic [4:0] S_CUR5    = 5'd25;
  localparam logic [4:0] S_CUR6    = 5'd26;
  localparam logic [4:0] S_CAW     = 5'd27;
  localparam logic [4:0] S_VMR0    = 5'd28;
  localparam logic [4:0] S_VMR1    = 5'd29;
  localparam logic [4:0] S_FIN     = 5'd30;

  logic [4:0] state;
  logic [4:0] ret;       // where to go when the multiplier is done
  logic [4:0] conv_ret;  // where to go after a milli to q16 conversion

  mul_req_t req;
  mul_rsp_t rsp;

  // configuration registers
  logic signed [31:0] target;
  logic signed [15:0] vlim;
  logic [14:0]        climit;

  // loop state
  logic [TW-1:0] tick_phase;
  logic [VW-1:0] vel_phase;
  q48_t prev_err;
  q48_t pc;
  q48_t prev_pos;
  q48_t mv;
  q48_t vi;
  q48_t vcmd;
  q48_t ci;

  // per tick scratch
  logic [9:0]        adc;
  q48_t              pos;
  logic [32:0]       u_reg;
  logic [13:0]       wrem;
  logic [31:0]       conv_x;
  logic [21:0]       cq;
  logic [10:0]       crem;
  logic [21:0]       conv_val;
  q48_t              err_r;
  q48_t              diff_r;
  q48_t              t1;
  q48_t              acc;
  q48_t              verr;
  q48_t              cerr;
  logic signed [31:0] volts;
  logic signed [5:0] vout;
  logic signed [31:0] vmr;

  // result register
  logic              out_valid;
  logic [8:0]        out_hi;
  logic [8:0]        out_lo;
  logic signed [5:0] out_volts;
  logic signed [31:0] out_vel;
  logic signed [15:0] out_ma;

  // combinational helpers
  logic signed [33:0] u_now;
  logic [12:0]        wr_c;
  logic [16:0]        vlim_mag;
  q48_t               lim_c;
  q48_t               r48;
  q48_t               whole_c;
  logic signed [22:0] cur_c;
  logic signed [11:0] n_s;
  logic [20:0]        dprod;
  logic [8:0]         duty_raw;
  logic [8:0]         duty;
  logic signed [10:0] d_s;
  logic [9:0]         d_mag;
  logic [21:0]        ma_prod;
  logic signed [15:0] ma_c;

  cmpc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // target offset by whole turns so the remainder search sees a positive value
  assign u_now    = 34'(target) + WRAP_OFFSET;
  assign wr_c     = (wrem >= WRAP_MRAD) ? 13'(wrem - WRAP_MRAD) : wrem[12:0];
  assign vlim_mag = vlim[15] ? 17'(-$signed(17'(vlim))) : 17'(vlim);
  assign lim_c    = 48'(conv_val);
  assign r48      = sat48(64'(rsp.r));

  // pi truncated toward zero to whole volts
  assign whole_c = {acc[47:16] + 32'(acc[47] && (acc[15:0] != '0)), 16'b0};

  // adc code 512 is zero current, 3200 q16 per code
  assign cur_c = 23'sd1638400 - $signed(23'(adc) * 23'd3200);

  // duty = (volts * 25 + 600) / 3 with a reciprocal multiply
  assign n_s      = 12'(vout) * 12'sd25 + 12'sd600;
  assign dprod    = 21'(n_s[10:0]) * 21'd1366;
  assign duty_raw = dprod[20:12];
  always_comb begin
    if (duty_raw > 9'(DUTY_MAX)) duty = 9'(DUTY_MAX);
    else if (duty_raw < 9'(DUTY_MIN)) duty = 9'(DUTY_MIN);
    else duty = duty_raw;
  end

  // current in milliamperes, truncated toward zero
  assign d_s     = 11'sd512 - $signed({1'b0, adc});
  assign d_mag   = d_s[10] ? 10'(-d_s) : 10'(d_s);
  assign ma_prod = 22'(d_mag) * 22'd3125;
  assign ma_c    = d_s[10] ? -$signed({1'b0, ma_prod[20:6]}) : $signed({1'b0, ma_prod[20:6]});

  assign tick.ready              = (state == S_IDLE);
  assign cfg.ready               = 1'b1;
  assign result.valid            = out_valid;
  assign result.pwm_high_compare = out_hi;
  assign result.pwm_low_compare  = out_lo;
  assign result.drive_volts      = out_volts;
  assign result.velocity_mrad_s  = out_vel;
  assign result.current_ma       = out_ma;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      req.start  <= 1'b0;
      target     <= '0;
      vlim       <= 16'sd1000;
      climit     <= 15'd1000;
      tick_phase <= '0;
      vel_phase  <= '0;
      prev_err   <= '0;
      pc         <= '0;
      prev_pos   <= '0;
      mv         <= '0;
      vi         <= '0;
      vcmd       <= '0;
      ci         <= '0;
      out_valid  <= 1'b0;
    end else begin
      // register writes, accepted on any cycle
      if (cfg.valid) begin
        case (cfg.index)
          REG_TARGET:    target <= $signed(cfg.data);
          REG_VEL_LIMIT: vlim   <= $signed(cfg.data[15:0]);
          REG_CUR_LIMIT: climit <= cfg.data[14:0];
          default: ;
        endcase
      end

      // the final state reloads the result register itself
      if (out_valid && result.ready && state != S_FIN) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            adc   <= tick.current_sample;
            req   <= mk_req(50'(tick.encoder_count), POS_RCP, SH_24, 1'b1);
            ret   <= S_POS;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // start is a single cycle pulse
          req.start <= 1'b0;
          if (rsp.done) state <= ret;
        end
        S_POS: begin
          pos   <= r48;
          u_reg <= u_now[32:0];
          if (tick_phase == '0) begin
            req   <= mk_req(50'(u_now), WRAP_RCP, SH_33, 1'b0);
            ret   <= S_WRAP_Q;
            state <= S_WAIT;
          end else if (vel_phase == '0) begin
            state <= S_VEL0;
          end else begin
            state <= S_CUR0;
          end
        end
        // target modulo one turn
        S_WRAP_Q: begin
          wrem  <= 14'(u_reg - 33'(rsp.r[20:0]) * 33'd6280);
          state <= S_WRAP_C;
        end
        S_WRAP_C: begin
          conv_x   <= 32'({wr_c, 16'b0}) + 32'd500;
          req      <= mk_req(50'(32'({wr_c, 16'b0}) + 32'd500), MILLI_RCP, SH_32, 1'b0);
          ret      <= S_CONV_Q;
          conv_ret <= S_ERR;
          state    <= S_WAIT;
        end
        // milli units to q16: quotient estimate, then one correction
        S_CONV_Q: begin
          cq    <= rsp.r[21:0];
          crem  <= 11'(conv_x - 32'(rsp.r[21:0]) * 32'd1000);
          state <= S_CONV_C;
        end
        S_CONV_C: begin
          conv_val <= cq + 22'(crem >= 11'd1000);
          state    <= conv_ret;
        end
        // position pd loop
        S_ERR: begin
          err_r <= sat48($signed(64'(conv_val)) - 64'(pos));
          state <= S_PD0;
        end
        S_PD0: begin
          diff_r   <= sat48(64'(err_r) - 64'(prev_err));
          prev_err <= err_r;
          req      <= mk_req(50'(err_r), G_PP, SH_16, 1'b1);
          ret      <= S_PD1;
          state    <= S_WAIT;
        end
        S_PD1: begin
          t1    <= r48;
          req   <= mk_req(50'(diff_r), G_PD, SH_16, 1'b1);
          ret   <= S_PD2;
          state <= S_WAIT;
        end
        S_PD2: begin
          acc      <= sat48(64'(t1) + 64'(r48));
          conv_x   <= 32'({vlim_mag, 16'b0}) + 32'd500;
          req      <= mk_req(50'(32'({vlim_mag, 16'b0}) + 32'd500), MILLI_RCP, SH_32, 1'b0);
          ret      <= S_CONV_Q;
          conv_ret <= S_PCLAMP;
          state    <= S_WAIT;
        end
        S_PCLAMP: begin
          if (acc >= lim_c) pc <= lim_c;
          else if (acc <= -lim_c) pc <= -lim_c;
          else pc <= acc;
          state <= (vel_phase == '0) ? S_VEL0 : S_CUR0;
        end
        // velocity pi loop
        S_VEL0: begin
          req      <= mk_req(50'(pos) - 50'(prev_pos), VEL_K, SH_16, 1'b1);
          prev_pos <= pos;
          ret      <= S_VEL1;
          state    <= S_WAIT;
        end
        S_VEL1: begin
          mv    <= r48;
          state <= S_VEL2;
        end
        S_VEL2: begin
          verr  <= sat48(64'(pc) - 64'(mv));
          state <= S_VEL3;
        end
        S_VEL3: begin
          vi    <= sat48(64'(vi) + 64'(verr));
          state <= S_VEL4;
        end
        S_VEL4: begin
          req   <= mk_req(50'(vi), G_VI, SH_16, 1'b1);
          ret   <= S_VEL5;
          state <= S_WAIT;
        end
        S_VEL5: begin
          acc      <= sat48(64'(verr) * 64'sd3 + 64'(r48));
          conv_x   <= 32'({climit, 16'b0}) + 32'd500;
          req      <= mk_req(50'(32'({climit, 16'b0}) + 32'd500), MILLI_RCP, SH_32, 1'b0);
          ret      <= S_CONV_Q;
          conv_ret <= S_VCLAMP;
          state    <= S_WAIT;
        end
        S_VCLAMP: begin
          if (acc >= lim_c) begin
            req   <= mk_req(50'(sat48(64'(acc) - 64'(lim_c))), G_VAW, SH_16, 1'b1);
            vcmd  <= lim_c;
            ret   <= S_VAW;
            state <= S_WAIT;
          end else if (acc <= -lim_c) begin
            req   <= mk_req(50'(acc) + 50'(lim_c), G_VAW, SH_16, 1'b1);
            vcmd  <= -lim_c;
            ret   <= S_VAW;
            state <= S_WAIT;
          end else begin
            vcmd  <= acc;
            state <= S_CUR0;
          end
        end
        S_VAW: begin
          vi    <= sat48(64'(vi) - 64'(r48));
          state <= S_CUR0;
        end
        // current pi loop
        S_CUR0: begin
          cerr  <= sat48(64'(vcmd) - 64'(cur_c));
          state <= S_CUR1;
        end
        S_CUR1: begin
          ci    <= sat48(64'(ci) + 64'(cerr));
          req   <= mk_req(50'(cerr), G_CP, SH_16, 1'b1);
          ret   <= S_CUR2;
          state <= S_WAIT;
        end
        S_CUR2: begin
          t1    <= r48;
          req   <= mk_req(50'(ci), G_CI, SH_16, 1'b1);
          ret   <= S_CUR3;
          state <= S_WAIT;
        end
        S_CUR3: begin
          acc   <= sat48(64'(t1) + 64'(r48));
          req   <= mk_req(50'(mv), G_KT, SH_16, 1'b1);
          ret   <= S_CUR4;
          state <= S_WAIT;
        end
        S_CUR4: begin
          // whole volts plus back-emf feedforward
          acc   <= sat48(64'(whole_c) + 64'(r48));
          state <= S_CUR5;
        end
        S_CUR5: begin
          volts <= $signed(acc[47:16] + 32'(acc[47] && (acc[15:0] != '0)));
          state <= S_CUR6;
        end
        S_CUR6: begin
          if (volts >= 32'sd24) begin
            req   <= mk_req(50'(volts) - 50'sd24, G_CAW, SH_0, 1'b0);
            vout  <= 6'sd24;
            ret   <= S_CAW;
            state <= S_WAIT;
          end else if (volts <= -32'sd24) begin
            req   <= mk_req(50'(volts) + 50'sd24, G_CAW, SH_0, 1'b0);
            vout  <= -6'sd24;
            ret   <= S_CAW;
            state <= S_WAIT;
          end else begin
            vout  <= $signed(volts[5:0]);
            state <= S_VMR0;
          end
        end
        S_CAW: begin
          ci    <= sat48(64'(ci) - 64'(rsp.r));
          state <= S_VMR0;
        end
        // velocity report in mrad/s
        S_VMR0: begin
          req   <= mk_req(50'(mv), K_MILLI, SH_16, 1'b0);
          ret   <= S_VMR1;
          state <= S_WAIT;
        end
        S_VMR1: begin
          vmr   <= sat32(64'(rsp.r));
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_hi    <= duty + 9'd8;
            out_lo    <= duty - 9'd8;
            out_volts <= vout;
            out_vel   <= vmr;
            out_ma    <= ma_c;
            if (tick_phase == TW'(POSITION_DIVIDER - 1)) begin
              tick_phase <= '0;
              vel_phase  <= '0;
            end else begin
              tick_phase <= tick_phase + 1'b1;
              if (vel_phase == VW'(VELOCITY_DIVIDER - 1)) vel_phase <= '0;
              else vel_phase <= vel_phase + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
